FILE: sv/e2q_pkg.sv
// Package for the Euler-angle to quaternion core.
// Holds CORDIC constants and the arctangent table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_BITS = 5;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    function automatic logic signed [33:0] atan_entry(input logic [STEP_BITS-1:0] idx);
        logic signed [33:0] r;
        begin
            case (idx)
                5'd0: r = 34'sh20000000;
                5'd1: r = 34'sh12E4051D;
                5'd2: r = 34'sh09FB385B;
                5'd3: r = 34'sh051111D4;
                5'd4: r = 34'sh028B0D43;
                5'd5: r = 34'sh0145D7E1;
                5'd6: r = 34'sh00A2F61E;
                5'd7: r = 34'sh00517C55;
                5'd8: r = 34'sh0028BE53;
                5'd9: r = 34'sh00145F2E;
                5'd10: r = 34'sh000A2F98;
                5'd11: r = 34'sh000517CC;
                5'd12: r = 34'sh00028BE6;
                5'd13: r = 34'sh000145F3;
                5'd14: r = 34'sh0000A2F9;
                5'd15: r = 34'sh0000517C;
                5'd16: r = 34'sh000028BE;
                5'd17: r = 34'sh0000145F;
                5'd18: r = 34'sh00000A2F;
                5'd19: r = 34'sh00000517;
                5'd20: r = 34'sh0000028B;
                5'd21: r = 34'sh00000145;
                5'd22: r = 34'sh000000A2;
                5'd23: r = 34'sh00000051;
                5'd24: r = 34'sh00000028;
                5'd25: r = 34'sh00000014;
                5'd26: r = 34'sh0000000A;
                5'd27: r = 34'sh00000005;
                5'd28: r = 34'sh00000002;
                5'd29: r = 34'sh00000001;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

FILE: sv/e2q_cell.sv
// One CORDIC rotation cell for three angles at once.
// Depends on e2q_pkg for the arctangent table.
`timescale 1ns / 1ps
`default_nettype none
module e2q_cell
    import e2q_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [33:0] x_in [3],
    input  wire logic signed [33:0] y_in [3],
    input  wire logic signed [33:0] z_in [3],
    output logic signed [33:0]      x_out [3],
    output logic signed [33:0]      y_out [3],
    output logic signed [33:0]      z_out [3]
);
    localparam logic signed [33:0] ATAN = atan_entry(STEP_BITS'(STEP));
    logic signed [33:0] x_reg [3];
    logic signed [33:0] y_reg [3];
    logic signed [33:0] z_reg [3];
    logic signed [33:0] x_next [3];
    logic signed [33:0] y_next [3];
    logic signed [33:0] z_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (!z_in[k][33])
            begin
                x_next[k] = x_in[k] - (y_in[k] >>> STEP);
                y_next[k] = y_in[k] + (x_in[k] >>> STEP);
                z_next[k] = z_in[k] - ATAN;
            end
            else
            begin
                x_next[k] = x_in[k] + (y_in[k] >>> STEP);
                y_next[k] = y_in[k] - (x_in[k] >>> STEP);
                z_next[k] = z_in[k] + ATAN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule
`default_nettype wire

FILE: sv/e2q_combine.sv
// Combines sines and cosines into quaternion components over three stages.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none
module e2q_combine #(
    parameter int OUT_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic [2:0]         en,
    input  wire logic signed [33:0] s_in [3],
    input  wire logic signed [33:0] c_in [3],
    output logic [OUT_BITS-1:0]     q_out [4]
);
    localparam int SH = 62 - OUT_BITS;
    localparam logic signed [65:0] HALF = 66'sd1 <<< (SH - 1);
    localparam logic signed [65:0] ONE = 66'sd1 <<< (OUT_BITS - 2);

    logic signed [33:0] sr_reg, cr_reg, pr_reg [4];
    logic signed [65:0] t_reg [8];
    logic signed [65:0] p [4];
    logic signed [65:0] v [4];
    logic [OUT_BITS-1:0] q_reg [4];
    logic [OUT_BITS-1:0] q_next_w [4];

    always_comb
    begin
        p[0] = 66'(s_in[1]) * 66'(c_in[2]);
        p[1] = 66'(c_in[1]) * 66'(c_in[2]);
        p[2] = 66'(s_in[1]) * 66'(s_in[2]);
        p[3] = 66'(c_in[1]) * 66'(s_in[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sr_reg <= s_in[0];
            cr_reg <= c_in[0];
            for (int k = 0; k < 4; k++)
            begin
                pr_reg[k] <= 34'((p[k] + 66'sd536870912) >>> 30);
            end
        end
        if (en[1])
        begin
            t_reg[0] <= 66'(sr_reg) * 66'(pr_reg[1]);
            t_reg[1] <= 66'(cr_reg) * 66'(pr_reg[2]);
            t_reg[2] <= 66'(cr_reg) * 66'(pr_reg[0]);
            t_reg[3] <= 66'(sr_reg) * 66'(pr_reg[3]);
            t_reg[4] <= 66'(cr_reg) * 66'(pr_reg[3]);
            t_reg[5] <= 66'(sr_reg) * 66'(pr_reg[0]);
            t_reg[6] <= 66'(cr_reg) * 66'(pr_reg[1]);
            t_reg[7] <= 66'(sr_reg) * 66'(pr_reg[2]);
        end
        if (en[2])
        begin
            q_reg <= q_next_w;
        end
    end

    always_comb
    begin
        v[0] = (t_reg[0] - t_reg[1] + HALF) >>> SH;
        v[1] = (t_reg[2] + t_reg[3] + HALF) >>> SH;
        v[2] = (t_reg[4] - t_reg[5] + HALF) >>> SH;
        v[3] = (t_reg[6] + t_reg[7] + HALF) >>> SH;
        for (int k = 0; k < 4; k++)
        begin
            if (v[k] > ONE)
                q_next_w[k] = OUT_BITS'(ONE);
            else if (v[k] < -ONE)
                q_next_w[k] = OUT_BITS'(-ONE);
            else
                q_next_w[k] = OUT_BITS'(v[k]);
        end
    end

    assign q_out = q_reg;
endmodule
`default_nettype wire

FILE: sv/euler_to_quaternion_core.sv
// Top level of the Euler-angle to quaternion core.
// Depends on e2q_pkg, e2q_cell and e2q_combine.
//
// Usage: one beat on the s_axis side carries roll, pitch and yaw binary
// angles; one beat on the m_axis side carries the quaternion x, y, z, w
// in signed Q1.(OUT_BITS-2), saturated to plus or minus one.
// The pipeline is a row of 30 CORDIC cells, one per rotation step, that
// work on all three angles, followed by three combine stages, the last of
// which is the output register, 33 stages in total. Throughput is one beat
// per cycle while m_axis_tready does not stall the output, set by the
// one-step-per-cell CORDIC row. The pipeline advances as a whole whenever
// its last stage is empty or taken, so a stall on m_axis_tready freezes
// all stages and holds off s_axis_tready. Reset clears all valid bits;
// data registers keep junk.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion_core
    import e2q_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int OUT_BITS = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // roll_angle, pitch_angle, yaw_angle
    input  wire logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [((4*OUT_BITS+7)/8)*8-1:0] m_axis_tdata
);
    localparam int DEPTH = CORDIC_STEPS + 2;
    localparam int OW = ((4*OUT_BITS+7)/8)*8;

    logic [DEPTH:0] vld_reg;
    logic adv;
    logic signed [33:0] xs [CORDIC_STEPS+1][3];
    logic signed [33:0] ys [CORDIC_STEPS+1][3];
    logic signed [33:0] zs [CORDIC_STEPS+1][3];
    logic [OUT_BITS-1:0] q [4];

    assign adv = !vld_reg[DEPTH] || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-1:0], s_axis_tvalid};
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            xs[0][k] = CORDIC_GAIN_Q30;
            ys[0][k] = 34'sd0;
            zs[0][k] = ($signed({{(34-ANGLE_BITS){s_axis_tdata[k*ANGLE_BITS+ANGLE_BITS-1]}},
                                 s_axis_tdata[k*ANGLE_BITS +: ANGLE_BITS]})
                        <<< (32 - ANGLE_BITS)) >>> 1;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        e2q_cell #(.STEP(i)) u_cell (
            .clk(clk), .en(adv),
            .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
            .x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1])
        );
    end

    e2q_combine #(.OUT_BITS(OUT_BITS)) u_comb (
        .clk(clk), .en({adv, adv, adv}),
        .s_in(ys[CORDIC_STEPS]), .c_in(xs[CORDIC_STEPS]), .q_out(q)
    );

    assign m_axis_tvalid = vld_reg[DEPTH];
    assign m_axis_tdata = OW'({q[3], q[2], q[1], q[0]});
endmodule
`default_nettype wire

FILE: sv/e2q_checker.sv
// Port-level checks for the Euler-angle to quaternion core.
// Bound to euler_to_quaternion_core; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none
module e2q_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
endmodule

bind euler_to_quaternion_core e2q_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
